// File: rtl/ugns_pkg.sv
package ugns_pkg;

	// Field widths of the stream beats and the register port
	localparam int FUNC_W  = 2;
	localparam int ID_W    = 14;
	localparam int POS_W   = 16;
	localparam int OFS_W   = 5;
	localparam int ST_W    = 2;
	localparam int GS_W    = 6;
	localparam int SH_W    = 4;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// Input tdata layout, lowest field first, padded to whole bytes
	localparam int PID_LSB   = 0;
	localparam int PX_LSB    = PID_LSB + ID_W;
	localparam int PY_LSB    = PX_LSB + POS_W;
	localparam int PZ_LSB    = PY_LSB + POS_W;
	localparam int OFS_LSB   = PZ_LSB + POS_W;
	localparam int IN_DATA_W = ((OFS_LSB + OFS_W + 7) / 8) * 8;

	// Output tdata and tuser layout
	localparam int OUT_DATA_W = ((ID_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 1 + ST_W;

	// Parameter defaults
	localparam int GRID_DIM_DEF  = 32;
	localparam int CELL_CAP_DEF  = 16;
	localparam int MAX_ITEMS_DEF = 16384;

	localparam int NUM_OFFSETS = 27;

	// Register reset values
	localparam logic [POS_W-1:0] POS_LOW_RST   = 16'd819;
	localparam logic [POS_W-1:0] POS_HIGH_RST  = 16'd40141;
	localparam logic [GS_W-1:0]  GRID_SIZE_RST = 6'd20;
	localparam logic [SH_W-1:0]  CELL_SHIFT_RST = 4'd11;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_QUERY  = 2'd2
	} func_e_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_OFFGRID = 2'd2
	} status_e_t;

	typedef enum logic [2:0] {
		REG_POS_LOW    = 3'd0,
		REG_POS_HIGH_X = 3'd1,
		REG_POS_HIGH_Y = 3'd2,
		REG_POS_HIGH_Z = 3'd3,
		REG_GRID_X     = 3'd4,
		REG_GRID_Y     = 3'd5,
		REG_GRID_Z     = 3'd6,
		REG_CELL_SHIFT = 3'd7
	} reg_idx_e_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CALC,
		S_RDC,
		S_DEC,
		S_QRD,
		S_QOUT,
		S_CLEAR,
		S_CLRDONE
	} state_e_t;

	typedef enum logic {
		OUT_SUMMARY,
		OUT_MEMBER
	} out_src_e_t;

	typedef struct packed {
		logic [POS_W-1:0] pos_low;
		logic [POS_W-1:0] pos_high_x;
		logic [POS_W-1:0] pos_high_y;
		logic [POS_W-1:0] pos_high_z;
		logic [GS_W-1:0]  grid_size_x;
		logic [GS_W-1:0]  grid_size_y;
		logic [GS_W-1:0]  grid_size_z;
		logic [SH_W-1:0]  cell_shift;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic       take;
		logic       calc;
		logic       cnt_rd;
		logic       ins_wr;
		logic       mem_rd;
		logic       slot_clr;
		logic       slot_inc;
		logic       sweep_step;
		logic       out_load;
		out_src_e_t out_src;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              offgrid;
		logic              full;
		logic              empty;
		logic              slot_last;
		logic              sweep_last;
		logic              out_free;
	} sts_t;

	// Neighbor offset, each delta two-bit two's complement
	typedef struct packed {
		logic       ok;
		logic [1:0] dx;
		logic [1:0] dy;
		logic [1:0] dz;
	} ofs_t;

	localparam ofs_t OFS_ZERO = '{ok: 1'b1, dx: 2'b00, dy: 2'b00, dz: 2'b00};

	// Split k into dz = k/9-1, dx = (k%9)/3-1, dy = k%3-1
	function automatic ofs_t ofs_decode(input logic [OFS_W-1:0] k);
		ofs_t             o;
		logic [OFS_W-1:0] r9;
		logic [OFS_W-1:0] r3;
		o.ok = (k < OFS_W'(NUM_OFFSETS));
		if (k < 5'd9) begin
			o.dz = 2'b11;
			r9   = k;
		end else if (k < 5'd18) begin
			o.dz = 2'b00;
			r9   = k - 5'd9;
		end else begin
			o.dz = 2'b01;
			r9   = k - 5'd18;
		end
		if (r9 < 5'd3) begin
			o.dx = 2'b11;
			r3   = r9;
		end else if (r9 < 5'd6) begin
			o.dx = 2'b00;
			r3   = r9 - 5'd3;
		end else begin
			o.dx = 2'b01;
			r3   = r9 - 5'd6;
		end
		if (r3 == 5'd0) begin
			o.dy = 2'b11;
		end else if (r3 == 5'd1) begin
			o.dy = 2'b00;
		end else begin
			o.dy = 2'b01;
		end
		return o;
	endfunction

endpackage

// File: rtl/uniform_grid_neighbor_search.sv
// Channel     Dir  Handshake               Contents
// config      in   psel/penable/pwrite     8 registers at byte address 4*i, pready tied high
// items       in   s_axis_tvalid/tready    tuser: func; tdata: id, pos x/y/z, offset
// results     out  m_axis_tvalid/tready    tuser: present, status; tdata: id; tlast
//
// An insert, a clear-free query on an empty or off-grid cell, or an unused code goes
// from beat to beat through capture, cell lookup, count memory read and decide.
// A query on a filled cell then reads and sends its members in turn: the single read
// port of the member memory gives one member per read state, then an output state.
// Reset and each clear command sweep the count memory, one cell a cycle, over all
// 2**(3*clog2(GRID_DIM)) cells (32768 at defaults); no item beat is taken meanwhile.
// The output register holds a beat under m_axis_tready low; the next item is still taken.
module uniform_grid_neighbor_search #(
	parameter int GRID_DIM  = ugns_pkg::GRID_DIM_DEF,
	parameter int CELL_CAP  = ugns_pkg::CELL_CAP_DEF,
	parameter int MAX_ITEMS = ugns_pkg::MAX_ITEMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ugns_pkg::PADDR_W-1:0]      paddr,
	input  logic [ugns_pkg::PDATA_W-1:0]      pwdata,
	output logic [ugns_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// particle_id[13:0], pos_x[29:14], pos_y[45:30], pos_z[61:46], offset_index[66:62]
	input  logic [ugns_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// func[1:0]
	input  logic [ugns_pkg::FUNC_W-1:0]       s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// neighbor_id[13:0]
	output logic [ugns_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// present[0], status[2:1]
	output logic [ugns_pkg::OUT_USER_W-1:0]   m_axis_tuser,
	output logic                              m_axis_tlast
);

	ugns_pkg::cfg_t cfg;
	ugns_pkg::cmd_t cmd;
	ugns_pkg::sts_t sts;

	ugns_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ugns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ugns_dp #(
		.GRID_DIM  (GRID_DIM),
		.CELL_CAP  (CELL_CAP),
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd           (cmd),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// File: rtl/ugns_cfg.sv
module ugns_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ugns_pkg::PADDR_W-1:0]  paddr,
	input  logic [ugns_pkg::PDATA_W-1:0]  pwdata,
	output logic [ugns_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output ugns_pkg::cfg_t                cfg
);

	ugns_pkg::cfg_t         cfg_q;
	ugns_pkg::reg_idx_e_t   idx;
	logic                   wr_en;

	assign idx    = ugns_pkg::reg_idx_e_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_low     <= ugns_pkg::POS_LOW_RST;
			cfg_q.pos_high_x  <= ugns_pkg::POS_HIGH_RST;
			cfg_q.pos_high_y  <= ugns_pkg::POS_HIGH_RST;
			cfg_q.pos_high_z  <= ugns_pkg::POS_HIGH_RST;
			cfg_q.grid_size_x <= ugns_pkg::GRID_SIZE_RST;
			cfg_q.grid_size_y <= ugns_pkg::GRID_SIZE_RST;
			cfg_q.grid_size_z <= ugns_pkg::GRID_SIZE_RST;
			cfg_q.cell_shift  <= ugns_pkg::CELL_SHIFT_RST;
		end else if (wr_en) begin
			unique case (idx)
				ugns_pkg::REG_POS_LOW:    cfg_q.pos_low     <= pwdata[15:0];
				ugns_pkg::REG_POS_HIGH_X: cfg_q.pos_high_x  <= pwdata[15:0];
				ugns_pkg::REG_POS_HIGH_Y: cfg_q.pos_high_y  <= pwdata[15:0];
				ugns_pkg::REG_POS_HIGH_Z: cfg_q.pos_high_z  <= pwdata[15:0];
				ugns_pkg::REG_GRID_X:     cfg_q.grid_size_x <= pwdata[5:0];
				ugns_pkg::REG_GRID_Y:     cfg_q.grid_size_y <= pwdata[5:0];
				ugns_pkg::REG_GRID_Z:     cfg_q.grid_size_z <= pwdata[5:0];
				ugns_pkg::REG_CELL_SHIFT: cfg_q.cell_shift  <= pwdata[3:0];
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (idx)
			ugns_pkg::REG_POS_LOW:    prdata = 32'(cfg_q.pos_low);
			ugns_pkg::REG_POS_HIGH_X: prdata = 32'(cfg_q.pos_high_x);
			ugns_pkg::REG_POS_HIGH_Y: prdata = 32'(cfg_q.pos_high_y);
			ugns_pkg::REG_POS_HIGH_Z: prdata = 32'(cfg_q.pos_high_z);
			ugns_pkg::REG_GRID_X:     prdata = 32'(cfg_q.grid_size_x);
			ugns_pkg::REG_GRID_Y:     prdata = 32'(cfg_q.grid_size_y);
			ugns_pkg::REG_GRID_Z:     prdata = 32'(cfg_q.grid_size_z);
			ugns_pkg::REG_CELL_SHIFT: prdata = 32'(cfg_q.cell_shift);
		endcase
	end

endmodule

// File: rtl/ugns_dp.sv
module ugns_dp #(
	parameter int GRID_DIM  = ugns_pkg::GRID_DIM_DEF,
	parameter int CELL_CAP  = ugns_pkg::CELL_CAP_DEF,
	parameter int MAX_ITEMS = ugns_pkg::MAX_ITEMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ugns_pkg::cfg_t                    cfg,
	input  logic [ugns_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic [ugns_pkg::FUNC_W-1:0]       s_axis_tuser,
	input  ugns_pkg::cmd_t                    cmd,
	output ugns_pkg::sts_t                    sts,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [ugns_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic [ugns_pkg::OUT_USER_W-1:0]   m_axis_tuser,
	output logic                              m_axis_tlast
);

	localparam int AxW    = $clog2(GRID_DIM);
	localparam int CellAw = 3 * AxW;
	localparam int SlotW  = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
	localparam int CntW   = $clog2(CELL_CAP + 1);
	localparam int IdW    = (MAX_ITEMS >= 2 ** ugns_pkg::ID_W) ? ugns_pkg::ID_W
		: $clog2(MAX_ITEMS);
	localparam int CellN  = 2 ** CellAw;
	localparam int MembN  = 2 ** (CellAw + SlotW);
	localparam int PW     = ugns_pkg::POS_W;
	localparam int EW     = ugns_pkg::GS_W + 1;

	// Item registers
	logic [ugns_pkg::FUNC_W-1:0] func_q;
	logic [ugns_pkg::ID_W-1:0]   pid_q;
	logic [PW-1:0]               px_q;
	logic [PW-1:0]               py_q;
	logic [PW-1:0]               pz_q;
	logic [ugns_pkg::OFS_W-1:0]  ofs_q;

	// Cell lookup
	ugns_pkg::ofs_t   ofs;
	logic [PW-1:0]    cx;
	logic [PW-1:0]    cy;
	logic [PW-1:0]    cz;
	logic [PW:0]      nx;
	logic [PW:0]      ny;
	logic [PW:0]      nz;
	logic             offgrid_d;
	logic             offgrid_q;
	logic [CellAw-1:0] cell_q;

	// Stored id
	logic [IdW-1:0]   id_d;
	logic [IdW-1:0]   id_q;

	// Memories and their read registers
	logic [CntW-1:0]  cnt_mem [CellN];
	logic [IdW-1:0]   memb_mem [MembN];
	logic [CntW-1:0]  cnt_q;
	logic [IdW-1:0]   memb_q;
	logic [SlotW-1:0] slot_q;
	logic [CellAw-1:0] sweep_q;

	// Result fields
	logic                       full;
	logic                       empty;
	logic                       slot_last;
	logic [ugns_pkg::ID_W-1:0]  sum_id;
	ugns_pkg::status_e_t        sum_st;
	logic                       m_valid_q;
	logic [ugns_pkg::ID_W-1:0]  out_id_q;
	logic                       out_pres_q;
	logic                       out_last_q;
	ugns_pkg::status_e_t        out_st_q;

	function automatic logic [PW-1:0] axis_cell(
		input logic [PW-1:0]             pos,
		input logic [PW-1:0]             low,
		input logic [PW-1:0]             high,
		input logic [ugns_pkg::SH_W-1:0] sh
	);
		logic [PW-1:0] p;
		p = (pos < low) ? low : pos;
		p = (p > high) ? high : p;
		return p >> sh;
	endfunction

	function automatic logic [EW-1:0] eff_size(input logic [ugns_pkg::GS_W-1:0] gs);
		return ({1'b0, gs} > EW'(GRID_DIM)) ? EW'(GRID_DIM) : {1'b0, gs};
	endfunction

	function automatic logic [PW:0] step(input logic [PW-1:0] c, input logic [1:0] d);
		return {1'b0, c} + {{(PW - 1){d[1]}}, d};
	endfunction

	// Latch the input beat
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q <= s_axis_tuser;
			pid_q  <= s_axis_tdata[ugns_pkg::PID_LSB +: ugns_pkg::ID_W];
			px_q   <= s_axis_tdata[ugns_pkg::PX_LSB +: PW];
			py_q   <= s_axis_tdata[ugns_pkg::PY_LSB +: PW];
			pz_q   <= s_axis_tdata[ugns_pkg::PZ_LSB +: PW];
			ofs_q  <= s_axis_tdata[ugns_pkg::OFS_LSB +: ugns_pkg::OFS_W];
		end
	end

	// Clamp, bin and step to the neighbor cell; inserts use the home cell
	always_comb begin
		ofs = (func_q == ugns_pkg::FUNC_QUERY) ? ugns_pkg::ofs_decode(ofs_q)
			: ugns_pkg::OFS_ZERO;
		cx  = axis_cell(px_q, cfg.pos_low, cfg.pos_high_x, cfg.cell_shift);
		cy  = axis_cell(py_q, cfg.pos_low, cfg.pos_high_y, cfg.cell_shift);
		cz  = axis_cell(pz_q, cfg.pos_low, cfg.pos_high_z, cfg.cell_shift);
		nx  = step(cx, ofs.dx);
		ny  = step(cy, ofs.dy);
		nz  = step(cz, ofs.dz);
		offgrid_d = !ofs.ok
			|| !(nx < (PW + 1)'(eff_size(cfg.grid_size_x)))
			|| !(ny < (PW + 1)'(eff_size(cfg.grid_size_y)))
			|| !(nz < (PW + 1)'(eff_size(cfg.grid_size_z)));
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			cell_q    <= {nz[AxW-1:0], ny[AxW-1:0], nx[AxW-1:0]};
			offgrid_q <= offgrid_d;
		end
	end

	// Reduce the id into the id space
	if (MAX_ITEMS >= 2 ** ugns_pkg::ID_W) begin : g_id_wide
		assign id_d = IdW'(pid_q);
	end else begin : g_id_mod
		localparam int LgM = $clog2(MAX_ITEMS);
		localparam int K   = ugns_pkg::ID_W + LgM;
		localparam logic [ugns_pkg::ID_W:0] Recip = (ugns_pkg::ID_W + 1)'(
			((64'd1 << K) + 64'(MAX_ITEMS) - 64'd1) / 64'(MAX_ITEMS));
		localparam logic [ugns_pkg::ID_W-1:0] Modv = ugns_pkg::ID_W'(MAX_ITEMS);

		logic [2*ugns_pkg::ID_W:0]  prod;
		logic [ugns_pkg::ID_W-1:0]  q_q;
		logic [ugns_pkg::ID_W-1:0]  qm;

		// Quotient by reciprocal multiply, registered before the back multiply
		assign prod = pid_q * Recip;
		always_ff @(posedge clk) begin
			if (cmd.calc) begin
				q_q <= ugns_pkg::ID_W'(prod >> K);
			end
		end
		assign qm   = ugns_pkg::ID_W'(q_q * Modv);
		assign id_d = IdW'(pid_q - qm);
	end

	// Count memory: clearing sweep or insert on the write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.sweep_step) begin
			cnt_mem[sweep_q] <= '0;
		end else if (cmd.ins_wr) begin
			cnt_mem[cell_q] <= cnt_q + 1'b1;
		end
		if (cmd.cnt_rd) begin
			cnt_q <= cnt_mem[cell_q];
			id_q  <= id_d;
		end
	end

	// Member memory: append at the count, read at the slot
	always_ff @(posedge clk) begin
		if (cmd.ins_wr) begin
			memb_mem[{cell_q, cnt_q[SlotW-1:0]}] <= id_q;
		end
		if (cmd.mem_rd) begin
			memb_q <= memb_mem[{cell_q, slot_q}];
		end
	end

	// Advance the sweep and slot counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			slot_q  <= '0;
		end else begin
			if (cmd.sweep_step) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.slot_clr) begin
				slot_q <= '0;
			end else if (cmd.slot_inc) begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign full      = (cnt_q >= CntW'(CELL_CAP));
	assign empty     = (cnt_q == '0);
	assign slot_last = ((CntW'(slot_q) + 1'b1) == cnt_q);

	// Single-beat result of an item
	always_comb begin
		unique case (ugns_pkg::func_e_t'(func_q))
			ugns_pkg::FUNC_INSERT: begin
				sum_id = ugns_pkg::ID_W'(id_q);
				if (offgrid_q) begin
					sum_st = ugns_pkg::ST_OFFGRID;
				end else if (full) begin
					sum_st = ugns_pkg::ST_FULL;
				end else begin
					sum_st = ugns_pkg::ST_OK;
				end
			end
			ugns_pkg::FUNC_QUERY: begin
				sum_id = '0;
				sum_st = offgrid_q ? ugns_pkg::ST_OFFGRID : ugns_pkg::ST_OK;
			end
			default: begin
				sum_id = '0;
				sum_st = ugns_pkg::ST_OK;
			end
		endcase
	end

	// Output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_src == ugns_pkg::OUT_MEMBER) begin
				out_id_q   <= ugns_pkg::ID_W'(memb_q);
				out_pres_q <= 1'b1;
				out_last_q <= slot_last;
				out_st_q   <= ugns_pkg::ST_OK;
			end else begin
				out_id_q   <= sum_id;
				out_pres_q <= 1'b0;
				out_last_q <= 1'b1;
				out_st_q   <= sum_st;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = ugns_pkg::OUT_DATA_W'(out_id_q);
	assign m_axis_tuser  = {out_st_q, out_pres_q};
	assign m_axis_tlast  = out_last_q;

	assign sts.func       = func_q;
	assign sts.offgrid    = offgrid_q;
	assign sts.full       = full;
	assign sts.empty      = empty;
	assign sts.slot_last  = slot_last;
	assign sts.sweep_last = &sweep_q;
	assign sts.out_free   = !m_valid_q || m_axis_tready;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_valid_q || m_axis_tready))
		else $error("result loaded over a beat not yet taken");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |-> (!full && !offgrid_q))
		else $error("insert written to a full or off-grid cell");

	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_rd |-> (CntW'(slot_q) < cnt_q))
		else $error("member read beyond the cell count");

endmodule

// File: rtl/ugns_ctrl.sv
module ugns_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ugns_pkg::sts_t  sts,
	output ugns_pkg::cmd_t  cmd
);

	ugns_pkg::state_e_t state_q;
	ugns_pkg::state_e_t state_d;
	logic               query_hit;

	// A query on a filled on-grid cell streams its members
	assign query_hit = (sts.func == ugns_pkg::FUNC_QUERY) && !sts.offgrid && !sts.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ugns_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ugns_pkg::S_INIT: begin
				if (sts.sweep_last) state_d = ugns_pkg::S_IDLE;
			end
			ugns_pkg::S_IDLE: begin
				if (in_valid) state_d = ugns_pkg::S_CALC;
			end
			ugns_pkg::S_CALC: begin
				state_d = (sts.func == ugns_pkg::FUNC_CLEAR) ? ugns_pkg::S_CLEAR
					: ugns_pkg::S_RDC;
			end
			ugns_pkg::S_RDC: begin
				state_d = ugns_pkg::S_DEC;
			end
			ugns_pkg::S_DEC: begin
				if (query_hit) begin
					state_d = ugns_pkg::S_QRD;
				end else if (sts.out_free) begin
					state_d = ugns_pkg::S_IDLE;
				end
			end
			ugns_pkg::S_QRD: begin
				state_d = ugns_pkg::S_QOUT;
			end
			ugns_pkg::S_QOUT: begin
				if (sts.out_free) begin
					state_d = sts.slot_last ? ugns_pkg::S_IDLE : ugns_pkg::S_QRD;
				end
			end
			ugns_pkg::S_CLEAR: begin
				if (sts.sweep_last) state_d = ugns_pkg::S_CLRDONE;
			end
			ugns_pkg::S_CLRDONE: begin
				if (sts.out_free) state_d = ugns_pkg::S_IDLE;
			end
			default: begin
				state_d = ugns_pkg::S_INIT;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd         = '0;
		cmd.out_src = ugns_pkg::OUT_SUMMARY;
		in_ready    = 1'b0;
		unique case (state_q)
			ugns_pkg::S_INIT, ugns_pkg::S_CLEAR: begin
				cmd.sweep_step = 1'b1;
			end
			ugns_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ugns_pkg::S_CALC: begin
				cmd.calc = 1'b1;
			end
			ugns_pkg::S_RDC: begin
				cmd.cnt_rd = 1'b1;
			end
			ugns_pkg::S_DEC: begin
				if (query_hit) begin
					cmd.slot_clr = 1'b1;
				end else if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.ins_wr   = (sts.func == ugns_pkg::FUNC_INSERT) && !sts.offgrid
						&& !sts.full;
				end
			end
			ugns_pkg::S_QRD: begin
				cmd.mem_rd = 1'b1;
			end
			ugns_pkg::S_QOUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = ugns_pkg::OUT_MEMBER;
					cmd.slot_inc = !sts.slot_last;
				end
			end
			ugns_pkg::S_CLRDONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd.take = 1'b0;
			end
		endcase
	end

	a_take_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ugns_pkg::S_CALC))
		else $error("accepted beat not followed by cell lookup");

endmodule

// File: tb/tb_top.sv
module tb_top;
	import ugns_pkg::*;

	localparam int GRID_N      = GRID_DIM_DEF;
	localparam int CAP         = CELL_CAP_DEF;
	localparam int GRID_CELLS  = GRID_N * GRID_N * GRID_N;
	localparam int STALL_LIMIT = 150000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 40;
	localparam int DIR_ROWS    = 13;
	localparam int NUM_PHASES  = 5;

	// Code 3 is unused by the block
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            present;
		logic            last;
		status_e_t       status;
	} nbr_beat_t;

	typedef struct packed {
		logic [FUNC_W-1:0] fn;
		logic [4:0]        reps;
		logic [ID_W-1:0]   pid;
		logic [POS_W-1:0]  px;
		logic [POS_W-1:0]  py;
		logic [POS_W-1:0]  pz;
		logic [OFS_W-1:0]  k;
		logic              typed;
		nbr_beat_t         want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [PDATA_W-1:0]    pwdata = '0;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// particle_id, pos_x, pos_y, pos_z, offset_index, zero pad
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// func
	logic [FUNC_W-1:0]     s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// neighbor_id, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// present, status
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;

	// Shadow configuration
	logic [POS_W-1:0] cfg_pos_low = POS_LOW_RST;
	logic [POS_W-1:0] cfg_high_x = POS_HIGH_RST;
	logic [POS_W-1:0] cfg_high_y = POS_HIGH_RST;
	logic [POS_W-1:0] cfg_high_z = POS_HIGH_RST;
	logic [GS_W-1:0]  cfg_grid_x = GRID_SIZE_RST;
	logic [GS_W-1:0]  cfg_grid_y = GRID_SIZE_RST;
	logic [GS_W-1:0]  cfg_grid_z = GRID_SIZE_RST;
	logic [SH_W-1:0]  cfg_shift = CELL_SHIFT_RST;

	// Shadow cell lists
	logic [4:0]      cell_fill [GRID_CELLS];
	logic [ID_W-1:0] cell_ids [GRID_CELLS*CAP];

	nbr_beat_t neighbor_beats_q [$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	int        burst_left = 0;
	bit        hold_go = 1'b0;

	// Directed items under the reset configuration
	stim_row_t dir_tab [DIR_ROWS] = '{
		// nothing stored yet
		'{FUNC_QUERY, 5'd1, 14'd0, 16'd1000, 16'd1000, 16'd1000, 5'd13, 1'b1,
			'{14'd0, 1'b0, 1'b1, ST_OK}},
		// below the low bound: clamps into the corner cell
		'{FUNC_INSERT, 5'd1, 14'd16383, 16'd0, 16'd0, 16'd0, 5'd0, 1'b1,
			'{14'd16383, 1'b0, 1'b1, ST_OK}},
		// above the high bound: clamps into the last cell
		'{FUNC_INSERT, 5'd1, 14'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 1'b1,
			'{14'd0, 1'b0, 1'b1, ST_OK}},
		'{FUNC_QUERY, 5'd1, 14'd0, 16'd0, 16'd0, 16'd0, 5'd0, 1'b1,
			'{14'd0, 1'b0, 1'b1, ST_OFFGRID}},
		'{FUNC_QUERY, 5'd1, 14'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd26, 1'b1,
			'{14'd0, 1'b0, 1'b1, ST_OFFGRID}},
		'{FUNC_QUERY, 5'd1, 14'd16383, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd13, 1'b0,
			'{14'd0, 1'b0, 1'b0, ST_OK}},
		// offset beyond the 27 neighbors
		'{FUNC_QUERY, 5'd1, 14'd0, 16'd20000, 16'd20000, 16'd20000, 5'd31, 1'b1,
			'{14'd0, 1'b0, 1'b1, ST_OFFGRID}},
		'{FUNC_SPARE, 5'd1, 14'd16383, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 1'b1,
			'{14'd0, 1'b0, 1'b1, ST_OK}},
		// fill the corner cell up to capacity
		'{FUNC_INSERT, 5'd15, 14'd100, 16'd900, 16'd1500, 16'd2000, 5'd5, 1'b0,
			'{14'd0, 1'b0, 1'b0, ST_OK}},
		'{FUNC_INSERT, 5'd1, 14'd200, 16'd2047, 16'd0, 16'd819, 5'd0, 1'b1,
			'{14'd200, 1'b0, 1'b1, ST_FULL}},
		// full cell seen from its +x neighbor
		'{FUNC_QUERY, 5'd1, 14'd0, 16'd2100, 16'd0, 16'd0, 5'd10, 1'b0,
			'{14'd0, 1'b0, 1'b0, ST_OK}},
		'{FUNC_CLEAR, 5'd1, 14'd77, 16'd0, 16'd0, 16'd0, 5'd13, 1'b1,
			'{14'd0, 1'b0, 1'b1, ST_OK}},
		'{FUNC_QUERY, 5'd1, 14'd0, 16'd0, 16'd0, 16'd0, 5'd13, 1'b1,
			'{14'd0, 1'b0, 1'b1, ST_OK}}
	};

	uniform_grid_neighbor_search dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic log_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatches++;
		if (mismatches <= 50) begin
			$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		end
	endtask

	function automatic int eff_cells(input logic [GS_W-1:0] g);
		return (int'(g) < GRID_N) ? int'(g) : GRID_N;
	endfunction

	// Clamp one axis to the bounds (high wins) and shift down to a cell index
	function automatic int axis_cell(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] hi);
		logic [POS_W-1:0] p;
		p = pos;
		if (p < cfg_pos_low) begin
			p = cfg_pos_low;
		end
		if (p > hi) begin
			p = hi;
		end
		return int'(p >> cfg_shift);
	endfunction

	function automatic void queue_beat(input logic [ID_W-1:0] id, input logic present,
			input logic last, input status_e_t st);
		nbr_beat_t b;
		b.id      = id;
		b.present = present;
		b.last    = last;
		b.status  = st;
		neighbor_beats_q = {neighbor_beats_q, b};
	endfunction

	// Bin an insert, look up a neighbor cell on a query, update the cell lists
	task automatic bin_particle_item(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] pid,
			input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
			input logic [POS_W-1:0] pz, input logic [OFS_W-1:0] k);
		int sx;
		int sy;
		int sz;
		int cx;
		int cy;
		int cz;
		int nx;
		int ny;
		int nz;
		int n;
		int a;
		sx = eff_cells(cfg_grid_x);
		sy = eff_cells(cfg_grid_y);
		sz = eff_cells(cfg_grid_z);
		cx = axis_cell(px, cfg_high_x);
		cy = axis_cell(py, cfg_high_y);
		cz = axis_cell(pz, cfg_high_z);
		case (fn)
			FUNC_CLEAR: begin
				foreach (cell_fill[i]) cell_fill[i] = '0;
				queue_beat('0, 1'b0, 1'b1, ST_OK);
			end
			FUNC_INSERT: begin
				if (cx >= sx || cy >= sy || cz >= sz) begin
					queue_beat(pid, 1'b0, 1'b1, ST_OFFGRID);
				end else begin
					a = (cz * GRID_N + cy) * GRID_N + cx;
					n = int'(cell_fill[a]);
					if (n >= CAP) begin
						queue_beat(pid, 1'b0, 1'b1, ST_FULL);
					end else begin
						cell_ids[a*CAP + n] = pid;
						cell_fill[a] = 5'(n + 1);
						queue_beat(pid, 1'b0, 1'b1, ST_OK);
					end
				end
			end
			FUNC_QUERY: begin
				if (int'(k) >= NUM_OFFSETS) begin
					queue_beat('0, 1'b0, 1'b1, ST_OFFGRID);
				end else begin
					nz = cz + int'(k) / 9 - 1;
					nx = cx + (int'(k) % 9) / 3 - 1;
					ny = cy + int'(k) % 3 - 1;
					if (nx < 0 || nx >= sx || ny < 0 || ny >= sy || nz < 0 || nz >= sz) begin
						queue_beat('0, 1'b0, 1'b1, ST_OFFGRID);
					end else begin
						a = (nz * GRID_N + ny) * GRID_N + nx;
						n = int'(cell_fill[a]);
						if (n > CAP) begin
							n = CAP;
						end
						if (n == 0) begin
							queue_beat('0, 1'b0, 1'b1, ST_OK);
						end
						for (int i = 0; i < n; i++) begin
							queue_beat(cell_ids[a*CAP + i], 1'b1, (i == n - 1), ST_OK);
						end
					end
				end
			end
			default: begin
				queue_beat('0, 1'b0, 1'b1, ST_OK);
			end
		endcase
	endtask

	// Two-phase register write, then mirror it in the shadow copy
	task automatic write_reg(input reg_idx_e_t r, input logic [PDATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (r)
			REG_POS_LOW:    cfg_pos_low = v[POS_W-1:0];
			REG_POS_HIGH_X: cfg_high_x = v[POS_W-1:0];
			REG_POS_HIGH_Y: cfg_high_y = v[POS_W-1:0];
			REG_POS_HIGH_Z: cfg_high_z = v[POS_W-1:0];
			REG_GRID_X:     cfg_grid_x = v[GS_W-1:0];
			REG_GRID_Y:     cfg_grid_y = v[GS_W-1:0];
			REG_GRID_Z:     cfg_grid_z = v[GS_W-1:0];
			default:        cfg_shift = v[SH_W-1:0];
		endcase
	endtask

	task automatic set_grid(input int lo, input int hx, input int hy, input int hz,
			input int gx, input int gy, input int gz, input int sh);
		write_reg(REG_POS_LOW, lo);
		write_reg(REG_POS_HIGH_X, hx);
		write_reg(REG_POS_HIGH_Y, hy);
		write_reg(REG_POS_HIGH_Z, hz);
		write_reg(REG_GRID_X, gx);
		write_reg(REG_GRID_Y, gy);
		write_reg(REG_GRID_Z, gz);
		write_reg(REG_CELL_SHIFT, sh);
	endtask

	// Offer one beat in bursts with random gaps; predict once it is taken
	task automatic offer_item(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] pid,
			input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
			input logic [POS_W-1:0] pz, input logic [OFS_W-1:0] k,
			input logic typed, input nbr_beat_t want);
		int gap;
		int qlen;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W-OFS_LSB-OFS_W){1'b0}}, k, pz, py, px, pid};
		s_axis_tuser  <= fn;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		qlen = neighbor_beats_q.size();
		bin_particle_item(fn, pid, px, py, pz, k);
		if (typed) begin
			while (neighbor_beats_q.size() > qlen) void'(neighbor_beats_q.pop_back());
			neighbor_beats_q = {neighbor_beats_q, want};
		end
	endtask

	// Drop valid and let every pending beat come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (neighbor_beats_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Receiver: changing stall pattern, plus one long hold-off on request
	initial begin : rx_ready_gen
		int rx_mode;
		int cyc;
		rx_mode = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_go) begin
				hold_go = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (cyc % 50 == 0) begin
					rx_mode = $urandom_range(0, 3);
				end
				case (rx_mode)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= 1'($urandom_range(0, 1));
					2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
					default: m_axis_tready <= ((cyc % 5) < 2);
				endcase
			end
		end
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin : check_beats
		nbr_beat_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (neighbor_beats_q.size() == 0) begin
				log_mismatch("beat with nothing pending, id", 16'(m_axis_tdata[ID_W-1:0]),
					16'd0);
			end else begin
				w = neighbor_beats_q.pop_front();
				if (m_axis_tdata[ID_W-1:0] !== w.id)
					log_mismatch("neighbor_id", 16'(m_axis_tdata[ID_W-1:0]), 16'(w.id));
				if (m_axis_tuser[0] !== w.present)
					log_mismatch("present", 16'(m_axis_tuser[0]), 16'(w.present));
				if (m_axis_tuser[2:1] !== w.status)
					log_mismatch("status", 16'(m_axis_tuser[2:1]), 16'(w.status));
				if (m_axis_tlast !== w.last)
					log_mismatch("last", 16'(m_axis_tlast), 16'(w.last));
			end
		end
	end

	// Abort when neither side moves a beat for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t        row;
		logic [POS_W-1:0] hot_pos [3][3];
		logic [POS_W-1:0] pos [3];
		logic [FUNC_W-1:0] fn;
		logic [OFS_W-1:0] k;
		int               pick;
		int               spot;
		int               phase_items;

		foreach (cell_fill[i]) cell_fill[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			row = dir_tab[r];
			for (int j = 0; j < int'(row.reps); j++) begin
				offer_item(row.fn, row.pid + ID_W'(j), row.px, row.py, row.pz, row.k,
					row.typed, row.want);
			end
		end
		wait_drained();

		// Random phases, each under its own grid setup
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			phase_items = 85;
			case (ph)
				// whole range, coarsest cells: 2x2x2 grid fills fast
				0: set_grid(0, 65535, 65535, 65535, 32, 32, 32, 15);
				// low bound above the x high bound, sizes past the grid dimension
				1: set_grid(50000, 30000, 65535, 65535, 63, 16, 33, 12);
				// finest cells, many inserts fall off the grid
				2: set_grid(0, 47, 40, 3, 40, 32, 2, 0);
				// zero size along y: every cell off grid
				3: begin
					set_grid(819, 40141, 40141, 40141, 1, 0, 2, 11);
					phase_items = 30;
				end
				default: set_grid($urandom_range(0, 4000), $urandom_range(30000, 65535),
					$urandom_range(30000, 65535), $urandom_range(30000, 65535),
					$urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32),
					$urandom_range(10, 13));
			endcase
			for (int s = 0; s < 3; s++) begin
				hot_pos[s][0] = POS_W'($urandom_range(0, cfg_high_x));
				hot_pos[s][1] = POS_W'($urandom_range(0, cfg_high_y));
				hot_pos[s][2] = POS_W'($urandom_range(0, cfg_high_z));
			end
			for (int n = 0; n < phase_items; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					fn = FUNC_CLEAR;
				end else if (pick < 5) begin
					fn = FUNC_SPARE;
				end else if (pick < 50) begin
					fn = FUNC_INSERT;
				end else begin
					fn = FUNC_QUERY;
				end
				// mostly hit a few hot spots so cells fill and queries find members
				spot = $urandom_range(0, 2);
				for (int a = 0; a < 3; a++) begin
					pos[a] = ($urandom_range(0, 3) != 0) ?
						(hot_pos[spot][a] ^ POS_W'($urandom_range(0, 3))) : POS_W'($urandom);
				end
				k = ($urandom_range(0, 1) != 0) ? OFS_W'(13) : OFS_W'($urandom_range(0, 31));
				if (ph == 1 && n == 12) begin
					hold_go = 1'b1;
				end
				offer_item(fn, ID_W'($urandom), pos[0], pos[1], pos[2], k, 1'b0, '0);
			end
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: uniform_grid_neighbor_search.f
rtl/ugns_pkg.sv
rtl/ugns_cfg.sv
rtl/ugns_dp.sv
rtl/ugns_ctrl.sv
rtl/uniform_grid_neighbor_search.sv
tb/tb_top.sv
